// ===== rtl/core/datagram_ring_fifo_tail_drop_defines.svh =====
// Assertion macros shared by the datagram ring RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef DATAGRAM_RING_FIFO_TAIL_DROP_DEFINES_SVH
`define DATAGRAM_RING_FIFO_TAIL_DROP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DRTD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("drtd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DRTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("drtd assertion failed");

`endif

// ===== rtl/core/drtd_pkg.sv =====
// Package for the datagram ring: widths, codes, state encoding, shared structs.
// No dependencies.
package drtd_pkg;

  localparam int RING_SLOTS_DEF  = 8;
  localparam int MAX_PAYLOAD_DEF = 250;
  localparam int DROP_WIDTH_DEF  = 32;

  localparam int MAC_W      = 48;
  localparam int OFF_W      = 8;
  localparam int SLOT_BYTES = 256;

  // func field codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RD   = 2'b10
  } st_t;

  // read-side result fields (dropped count travels separately)
  typedef struct packed {
    logic             read_valid;
    logic [MAC_W-1:0] out_mac;
    logic [OFF_W-1:0] out_length;
    logic [OFF_W-1:0] out_byte;
    logic             out_byte_valid;
    logic             last_of_datagram;
  } rd_res_t;

  // read pointer update
  typedef struct packed {
    logic             tail_adv;
    logic [OFF_W-1:0] read_offset;
    logic [OFF_W-1:0] read_limit;
  } rd_upd_t;

endpackage

// ===== rtl/core/drtd_in_if.sv =====
// Input channel: one write or read transaction per handshake.
// Depends on drtd_pkg.
interface drtd_in_if;
  import drtd_pkg::*;
  logic             valid;
  logic             ready;
  logic             func;
  logic [MAC_W-1:0] src_mac;
  logic [OFF_W-1:0] data_byte;
  logic             byte_valid;
  logic             end_of_datagram;
  logic [OFF_W-1:0] read_capacity;

  modport source (output valid, func, src_mac, data_byte, byte_valid, end_of_datagram,
                  read_capacity, input ready);
  modport sink   (input valid, func, src_mac, data_byte, byte_valid, end_of_datagram,
                  read_capacity, output ready);
endinterface

// ===== rtl/core/drtd_out_if.sv =====
// Result channel: one result transaction per accepted input transaction.
// Depends on drtd_pkg.
interface drtd_out_if #(
  parameter int DROP_W = drtd_pkg::DROP_WIDTH_DEF
);
  import drtd_pkg::*;
  logic              valid;
  logic              ready;
  logic              read_valid;
  logic [MAC_W-1:0]  out_mac;
  logic [OFF_W-1:0]  out_length;
  logic [OFF_W-1:0]  out_byte;
  logic              out_byte_valid;
  logic              last_of_datagram;
  logic [DROP_W-1:0] dropped_count;

  modport source (output valid, read_valid, out_mac, out_length, out_byte, out_byte_valid,
                  last_of_datagram, dropped_count, input ready);
  modport sink   (input valid, read_valid, out_mac, out_length, out_byte, out_byte_valid,
                  last_of_datagram, dropped_count, output ready);
endinterface

// ===== rtl/core/drtd_cfg_if.sv =====
// Configuration write channel carrying the enable register.
// No dependencies.
interface drtd_cfg_if;
  logic valid;
  logic ready;
  logic enable;

  modport source (output valid, enable, input ready);
  modport sink   (input valid, enable, output ready);
endinterface

// ===== rtl/core/datagram_ring_fifo_tail_drop.sv =====
// Top level of the datagram ring with tail drop: control, pointers, slot RAMs.
// Depends on drtd_pkg, the channel interfaces, drtd_ram, drtd_rd_resp and the defines header.
//
//  channel | dir | transaction
//  --------+-----+-----------------------------------------------------------
//  in_ch   | in  | write one datagram byte (func=0) or read one byte (func=1)
//  out_ch  | out | exactly one result per input transaction, in order
//  cfg_ch  | in  | enable register write, always ready
//
//  Write transactions: slot RAM writes happen at the accept edge.
//  Read transactions wait in ST_RD for the slot RAMs' registered read data.
//  Reset: rst_n synchronous; ring empty, drop count zero, block disabled.
//  Output is registered; a new transaction is taken while the held result is
//  being taken, and in_ch stalls while out_ch is stalled or a read is in ST_RD.
module datagram_ring_fifo_tail_drop #(
  parameter int RING_SLOTS  = drtd_pkg::RING_SLOTS_DEF,
  parameter int MAX_PAYLOAD = drtd_pkg::MAX_PAYLOAD_DEF,
  parameter int DROP_WIDTH  = drtd_pkg::DROP_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  drtd_in_if.sink    in_ch,
  drtd_out_if.source out_ch,
  drtd_cfg_if.sink   cfg_ch
);
  import drtd_pkg::*;
  `include "datagram_ring_fifo_tail_drop_defines.svh"

  localparam int SLOT_W    = $clog2(RING_SLOTS);
  localparam int PAY_DEPTH = RING_SLOTS * SLOT_BYTES;
  localparam int PAY_AW    = $clog2(PAY_DEPTH);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_SLOTS - 1);
  localparam logic [OFF_W-1:0]  MAX_OFF   = OFF_W'(MAX_PAYLOAD);

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] i);
    return (i == LAST_SLOT) ? '0 : i + SLOT_W'(1);
  endfunction

  // control and pointer state
  st_t                   state_r, state_nxt;
  logic                  enable_r, enable_nxt;
  logic [SLOT_W-1:0]     head_r, head_nxt;
  logic [SLOT_W-1:0]     tail_r, tail_nxt;
  logic [DROP_WIDTH-1:0] drop_r, drop_nxt;
  logic                  wr_active_r, wr_active_nxt;
  logic                  wr_discard_r, wr_discard_nxt;
  logic [OFF_W-1:0]      woff_r, woff_nxt;
  logic [OFF_W-1:0]      roff_r, roff_nxt;
  logic [OFF_W-1:0]      rlim_r, rlim_nxt;
  logic [OFF_W-1:0]      cap_r, cap_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  rd_res_t               res_r, res_nxt;
  logic [DROP_WIDTH-1:0] out_drop_r, out_drop_nxt;

  // handshakes
  logic in_ready, in_acc, out_free, wr_item, rd_item, rd_done;

  // write datapath
  logic             disc_now;
  logic [OFF_W-1:0] off_now, off_inc;
  logic             mac_we, pay_we, len_we;

  // RAM read data and read response
  logic [MAC_W-1:0] mac_q;
  logic [OFF_W-1:0] len_q, byte_q;
  rd_res_t          rd_res;
  rd_upd_t          rd_upd;

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign in_acc   = in_ch.valid && in_ready;
  assign wr_item  = in_acc && enable_r && (in_ch.func == FUNC_WRITE);
  assign rd_item  = in_acc && enable_r && (in_ch.func == FUNC_READ);
  assign rd_done  = (state_r == ST_RD) && out_free;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  // Fullness is judged once, at the first transaction of a datagram.
  assign disc_now = wr_active_r ? wr_discard_r : (next_slot(head_r) == tail_r);
  assign off_now  = wr_active_r ? woff_r : '0;
  assign pay_we   = wr_item && in_ch.byte_valid && !disc_now && (off_now < MAX_OFF);
  assign off_inc  = pay_we ? off_now + OFF_W'(1) : off_now;
  assign mac_we   = wr_item && !wr_active_r && !disc_now;
  assign len_we   = wr_item && in_ch.end_of_datagram && !disc_now;

  drtd_ram #(.WIDTH(MAC_W), .DEPTH(RING_SLOTS)) u_mac_ram (
    .clk   (clk),
    .we    (mac_we),
    .waddr (head_r),
    .wdata (in_ch.src_mac),
    .re    (rd_item),
    .raddr (tail_r),
    .rdata (mac_q)
  );

  drtd_ram #(.WIDTH(OFF_W), .DEPTH(RING_SLOTS)) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (head_r),
    .wdata (off_inc),
    .re    (rd_item),
    .raddr (tail_r),
    .rdata (len_q)
  );

  // payload address: slot index above byte offset
  drtd_ram #(.WIDTH(OFF_W), .DEPTH(PAY_DEPTH)) u_pay_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (PAY_AW'({head_r, off_now})),
    .wdata (in_ch.data_byte),
    .re    (rd_item),
    .raddr (PAY_AW'({tail_r, roff_r})),
    .rdata (byte_q)
  );

  // head/tail hold still between a read accept and its response, unless a disable clears them
  drtd_rd_resp u_rd_resp (
    .ring_empty    (head_r == tail_r),
    .read_offset   (roff_r),
    .read_limit    (rlim_r),
    .read_capacity (cap_r),
    .slot_length   (len_q),
    .slot_mac      (mac_q),
    .slot_byte     (byte_q),
    .res           (rd_res),
    .upd           (rd_upd)
  );

  always_comb begin
    state_nxt      = state_r;
    enable_nxt     = enable_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    drop_nxt       = drop_r;
    wr_active_nxt  = wr_active_r;
    wr_discard_nxt = wr_discard_r;
    woff_nxt       = woff_r;
    roff_nxt       = roff_r;
    rlim_nxt       = rlim_r;
    cap_nxt        = cap_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    res_nxt        = res_r;
    out_drop_nxt   = out_drop_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (rd_item) begin
            cap_nxt   = in_ch.read_capacity;
            state_nxt = ST_RD;
          end else begin
            // write transaction, or any transaction while disabled
            if (wr_item) begin
              if (in_ch.end_of_datagram) begin
                if (disc_now) begin
                  drop_nxt = drop_r + DROP_WIDTH'(1);
                end else begin
                  head_nxt = next_slot(head_r);
                end
                wr_active_nxt  = 1'b0;
                wr_discard_nxt = 1'b0;
                woff_nxt       = '0;
              end else begin
                wr_active_nxt  = 1'b1;
                wr_discard_nxt = disc_now;
                woff_nxt       = off_inc;
              end
            end
            out_valid_nxt = 1'b1;
            res_nxt       = '0;
            out_drop_nxt  = '0;
            if (wr_item) begin
              out_drop_nxt = (in_ch.end_of_datagram && disc_now) ?
                             drop_r + DROP_WIDTH'(1) : drop_r;
            end
          end
        end
      end
      ST_RD: begin
        if (rd_done) begin
          roff_nxt      = rd_upd.read_offset;
          rlim_nxt      = rd_upd.read_limit;
          tail_nxt      = rd_upd.tail_adv ? next_slot(tail_r) : tail_r;
          out_valid_nxt = 1'b1;
          res_nxt       = rd_res;
          out_drop_nxt  = drop_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Disable empties the ring and abandons any datagram in progress.
    if (cfg_ch.valid) begin
      enable_nxt = cfg_ch.enable;
      if (!cfg_ch.enable) begin
        head_nxt       = '0;
        tail_nxt       = '0;
        drop_nxt       = '0;
        wr_active_nxt  = 1'b0;
        wr_discard_nxt = 1'b0;
        woff_nxt       = '0;
        roff_nxt       = '0;
        rlim_nxt       = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      enable_r     <= 1'b0;
      head_r       <= '0;
      tail_r       <= '0;
      drop_r       <= '0;
      wr_active_r  <= 1'b0;
      wr_discard_r <= 1'b0;
      woff_r       <= '0;
      roff_r       <= '0;
      rlim_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      enable_r     <= enable_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      drop_r       <= drop_nxt;
      wr_active_r  <= wr_active_nxt;
      wr_discard_r <= wr_discard_nxt;
      woff_r       <= woff_nxt;
      roff_r       <= roff_nxt;
      rlim_r       <= rlim_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    cap_r      <= cap_nxt;
    res_r      <= res_nxt;
    out_drop_r <= out_drop_nxt;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.read_valid       = res_r.read_valid;
  assign out_ch.out_mac          = res_r.out_mac;
  assign out_ch.out_length       = res_r.out_length;
  assign out_ch.out_byte         = res_r.out_byte;
  assign out_ch.out_byte_valid   = res_r.out_byte_valid;
  assign out_ch.last_of_datagram = res_r.last_of_datagram;
  assign out_ch.dropped_count    = out_drop_r;

  // a committed datagram never makes the ring look empty
  `DRTD_ASSERT_NOW(a_head_not_tail, clk, rst_n, enable_r && !$stable(head_r), head_r != tail_r)
  // a read response always leaves the read state
  `DRTD_ASSERT_NEXT(a_rd_done_idle, clk, rst_n, rd_done, state_r == ST_IDLE && out_valid_r)
  // write offset stays within the slot payload size
  `DRTD_ASSERT_NOW(a_woff_range, clk, rst_n, wr_active_r, woff_r <= MAX_OFF)
  // a datagram in mid-read has offset below its latched limit
  `DRTD_ASSERT_NOW(a_roff_range, clk, rst_n, roff_r != '0, roff_r < rlim_r)
endmodule

// ===== rtl/core/drtd_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module drtd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ===== rtl/core/drtd_rd_resp.sv =====
// Read response: forms a read result from slot RAM data and the read pointers.
// Depends on drtd_pkg.
module drtd_rd_resp (
  input  logic                             ring_empty,
  input  logic [drtd_pkg::OFF_W-1:0]       read_offset,
  input  logic [drtd_pkg::OFF_W-1:0]       read_limit,
  input  logic [drtd_pkg::OFF_W-1:0]       read_capacity,
  input  logic [drtd_pkg::OFF_W-1:0]       slot_length,
  input  logic [drtd_pkg::MAC_W-1:0]       slot_mac,
  input  logic [drtd_pkg::OFF_W-1:0]       slot_byte,
  output drtd_pkg::rd_res_t                res,
  output drtd_pkg::rd_upd_t                upd
);
  import drtd_pkg::*;

  logic [OFF_W-1:0] lim;
  logic [OFF_W-1:0] off_inc;

  // limit latched at first byte of a datagram
  assign lim = (read_offset == '0) ?
               ((slot_length > read_capacity) ? read_capacity : slot_length) : read_limit;
  assign off_inc = read_offset + OFF_W'(1);

  always_comb begin
    res             = '0;
    upd.tail_adv    = 1'b0;
    upd.read_offset = read_offset;
    upd.read_limit  = read_limit;
    if (!ring_empty) begin
      res.read_valid = 1'b1;
      res.out_mac    = slot_mac;
      res.out_length = lim;
      if (lim == '0) begin
        // empty delivery marker
        res.last_of_datagram = 1'b1;
        upd.tail_adv         = 1'b1;
        upd.read_offset      = '0;
        upd.read_limit       = '0;
      end else begin
        res.out_byte       = slot_byte;
        res.out_byte_valid = 1'b1;
        if (off_inc >= lim) begin
          res.last_of_datagram = 1'b1;
          upd.tail_adv         = 1'b1;
          upd.read_offset      = '0;
          upd.read_limit       = '0;
        end else begin
          upd.read_offset = off_inc;
          upd.read_limit  = lim;
        end
      end
    end
  end
endmodule

// ===== tb/sv/datagram_ring_fifo_tail_drop_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for datagram_ring_fifo_tail_drop: directed and random traffic
// with an in-order result check against a shadow copy of the datagram ring.
// Depends on drtd_pkg, the drtd channel interfaces and the RTL top level.

import drtd_pkg::*;

typedef struct packed {
  logic             func;
  logic [MAC_W-1:0] src_mac;
  logic [OFF_W-1:0] data_byte;
  logic             byte_valid;
  logic             end_of_datagram;
  logic [OFF_W-1:0] read_capacity;
} ring_txn_t;

typedef struct packed {
  logic                      read_valid;
  logic [MAC_W-1:0]          out_mac;
  logic [OFF_W-1:0]          out_length;
  logic [OFF_W-1:0]          out_byte;
  logic                      out_byte_valid;
  logic                      last_of_datagram;
  logic [DROP_WIDTH_DEF-1:0] dropped_count;
} ring_result_t;

// Shadow of the ring: slot stores, pointers and the drop count, plus the
// queue of results still owed by the block, oldest first.
class ring_shadow;
  bit                      enabled;
  bit [MAC_W-1:0]          addr_mem [RING_SLOTS_DEF];
  bit [OFF_W-1:0]          size_mem [RING_SLOTS_DEF];
  bit [OFF_W-1:0]          byte_mem [RING_SLOTS_DEF][SLOT_BYTES];
  int unsigned             wr_ptr, rd_ptr;
  int unsigned             fill_pos, drain_pos, drain_len;
  bit                      fill_busy, fill_skip;
  bit [DROP_WIDTH_DEF-1:0] lost_count;
  ring_result_t            due_results[$];
  int                      mismatches;

  // Disable empties the ring, abandons any datagram and clears the drop count.
  function void set_enable(bit on);
    enabled = on;
    if (!on) begin
      wr_ptr     = 0;
      rd_ptr     = 0;
      fill_pos   = 0;
      drain_pos  = 0;
      drain_len  = 0;
      fill_busy  = 1'b0;
      fill_skip  = 1'b0;
      lost_count = '0;
    end
  endfunction

  function void note_transaction(ring_txn_t t);
    ring_result_t r;
    int unsigned  slot;
    r = '0;
    if (enabled) begin
      if (t.func == FUNC_WRITE) begin
        slot = wr_ptr;
        // Fullness is judged once, at the datagram's first write.
        if (!fill_busy) begin
          fill_busy = 1'b1;
          fill_pos  = 0;
          fill_skip = ((slot + 1) % RING_SLOTS_DEF) == rd_ptr;
          if (!fill_skip) addr_mem[slot] = t.src_mac;
        end
        if (t.byte_valid && !fill_skip && fill_pos < MAX_PAYLOAD_DEF) begin
          byte_mem[slot][fill_pos] = t.data_byte;
          fill_pos++;
        end
        if (t.end_of_datagram) begin
          if (fill_skip) begin
            lost_count++;
          end else begin
            size_mem[slot] = 8'(fill_pos);
            wr_ptr         = (slot + 1) % RING_SLOTS_DEF;
          end
          fill_busy = 1'b0;
          fill_skip = 1'b0;
          fill_pos  = 0;
        end
      end else if (rd_ptr != wr_ptr) begin
        slot = rd_ptr;
        // Capacity is latched at the first read of a datagram.
        if (drain_pos == 0) begin
          drain_len = 32'(size_mem[slot]);
          if (drain_len > 32'(t.read_capacity)) drain_len = 32'(t.read_capacity);
        end
        r.read_valid = 1'b1;
        r.out_mac    = addr_mem[slot];
        r.out_length = 8'(drain_len);
        if (drain_len == 0) begin
          // empty delivery: one marker result, slot freed
          r.last_of_datagram = 1'b1;
          drain_pos          = 0;
          rd_ptr             = (slot + 1) % RING_SLOTS_DEF;
        end else begin
          r.out_byte       = byte_mem[slot][drain_pos];
          r.out_byte_valid = 1'b1;
          drain_pos++;
          if (drain_pos >= drain_len) begin
            r.last_of_datagram = 1'b1;
            drain_pos          = 0;
            drain_len          = 0;
            rd_ptr             = (slot + 1) % RING_SLOTS_DEF;
          end
        end
      end
      r.dropped_count = lost_count;
    end
    due_results.push_back(r);
  endfunction

  function void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  function void check_result(ring_result_t got);
    ring_result_t want;
    if (due_results.size() == 0) begin
      $error("result transaction with no outstanding expectation");
      mismatches++;
      return;
    end
    want = due_results.pop_front();
    compare_field("read_valid", 64'(want.read_valid), 64'(got.read_valid));
    compare_field("out_mac", 64'(want.out_mac), 64'(got.out_mac));
    compare_field("out_length", 64'(want.out_length), 64'(got.out_length));
    compare_field("out_byte", 64'(want.out_byte), 64'(got.out_byte));
    compare_field("out_byte_valid", 64'(want.out_byte_valid), 64'(got.out_byte_valid));
    compare_field("last_of_datagram", 64'(want.last_of_datagram),
                  64'(got.last_of_datagram));
    compare_field("dropped_count", 64'(want.dropped_count), 64'(got.dropped_count));
  endfunction
endclass

module datagram_ring_fifo_tail_drop_tb;

  // Cycles without any accepted transaction before the run is called hung.
  // Worst legal quiet stretch is a long source gap plus a long sink stall
  // plus the phase pause.
  localparam int WATCHDOG_LIMIT = 2000;
  // Pause after the last result; reads pass through the registered slot RAMs.
  localparam int SETTLE_CYCLES  = 8;

  logic clk = 1'b0;
  logic rst_n;

  // Percentage of transactions preceded by a gap (source) or stall (sink).
  int gap_pct = 25;
  int ready_hold = 0;

  ring_shadow shadow;

  drtd_in_if                            in_ch();
  drtd_out_if #(.DROP_W(DROP_WIDTH_DEF)) out_ch();
  drtd_cfg_if                           cfg_ch();

  datagram_ring_fifo_tail_drop DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly no gap; of the gaps, most are short and a few are long.
  function automatic int pick_gap();
    if ($urandom_range(0, 99) >= gap_pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic ring_txn_t write_txn(logic [MAC_W-1:0] mac, logic [OFF_W-1:0] data,
                                          logic bv, logic eod);
    ring_txn_t t;
    t                 = '0;
    t.func            = FUNC_WRITE;
    t.src_mac         = mac;
    t.data_byte       = data;
    t.byte_valid      = bv;
    t.end_of_datagram = eod;
    // unused on writes, but randomized so the block must ignore it
    t.read_capacity   = 8'($urandom_range(0, 255));
    return t;
  endfunction

  function automatic ring_txn_t read_txn(logic [OFF_W-1:0] cap);
    ring_txn_t t;
    t               = '0;
    t.func          = FUNC_READ;
    t.read_capacity = cap;
    // write-side fields are noise on reads
    t.src_mac       = {16'($urandom()), $urandom()};
    t.data_byte     = 8'($urandom_range(0, 255));
    t.byte_valid    = 1'($urandom_range(0, 1));
    t.end_of_datagram = 1'($urandom_range(0, 1));
    return t;
  endfunction

  // Sink side: ready held low for random stretches.
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      out_ch.ready <= 1'b0;
      ready_hold--;
    end else begin
      ready_hold = pick_gap();
      out_ch.ready <= (ready_hold == 0);
      if (ready_hold > 0) ready_hold--;
    end
  end

  // Monitor: every accepted transaction is sampled at the edge that takes it.
  // Inputs are noted before results are checked; the output is registered,
  // so a result never belongs to an input taken at the same edge.
  always @(posedge clk) begin
    ring_txn_t    seen_in;
    ring_result_t seen_out;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) shadow.set_enable(cfg_ch.enable);
      if (in_ch.valid && in_ch.ready) begin
        seen_in.func            = in_ch.func;
        seen_in.src_mac         = in_ch.src_mac;
        seen_in.data_byte       = in_ch.data_byte;
        seen_in.byte_valid      = in_ch.byte_valid;
        seen_in.end_of_datagram = in_ch.end_of_datagram;
        seen_in.read_capacity   = in_ch.read_capacity;
        shadow.note_transaction(seen_in);
      end
      if (out_ch.valid && out_ch.ready) begin
        seen_out.read_valid       = out_ch.read_valid;
        seen_out.out_mac          = out_ch.out_mac;
        seen_out.out_length       = out_ch.out_length;
        seen_out.out_byte         = out_ch.out_byte;
        seen_out.out_byte_valid   = out_ch.out_byte_valid;
        seen_out.last_of_datagram = out_ch.last_of_datagram;
        seen_out.dropped_count    = out_ch.dropped_count;
        shadow.check_result(seen_out);
      end
    end
  end

  // Watchdog: counts consecutive cycles with no transaction on any channel.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready) || !rst_n)
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Valid is left high after acceptance; the next call either keeps it high
  // (back to back) or drops it for a gap, never both in one step.
  task automatic push_item(input ring_txn_t t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.func            <= t.func;
    in_ch.src_mac         <= t.src_mac;
    in_ch.data_byte       <= t.data_byte;
    in_ch.byte_valid      <= t.byte_valid;
    in_ch.end_of_datagram <= t.end_of_datagram;
    in_ch.read_capacity   <= t.read_capacity;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_enable_reg(input logic on);
    cfg_ch.valid  <= 1'b1;
    cfg_ch.enable <= on;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Stop sourcing, wait for every owed result, then let the pipeline go quiet.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (shadow.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Datagram sizes: mostly tiny, some empty, a few near or past the maximum payload.
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return $urandom_range(245, 262);
    if (r < 15) return 0;
    return $urandom_range(1, 6);
  endfunction

  // Interleaves reads with well-formed write datagrams; about one write in
  // twenty is noise with random byte_valid / end_of_datagram.
  task automatic run_random_phase(input int n, input int read_pct);
    logic [MAC_W-1:0] mac;
    logic [OFF_W-1:0] cap;
    logic             bv, eod, noise;
    int               left;
    bit               in_dgram;
    in_dgram = 1'b0;
    left     = 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < read_pct) begin
        cap = ($urandom_range(0, 99) < 25) ? 8'($urandom_range(0, 3))
                                            : 8'($urandom_range(0, 255));
        push_item(read_txn(cap));
      end else begin
        if (!in_dgram) begin
          in_dgram = 1'b1;
          left     = pick_len();
        end
        mac   = {16'($urandom()), $urandom()};
        noise = ($urandom_range(0, 19) == 0);
        bv    = noise ? 1'($urandom_range(0, 1)) : (left > 0);
        eod   = noise ? 1'($urandom_range(0, 1)) : (left <= 1);
        if (bv && left > 0) left--;
        if (eod) in_dgram = 1'b0;
        push_item(write_txn(mac, 8'($urandom_range(0, 255)), bv, eod));
      end
    end
  endtask

  initial begin : stimulus
    shadow = new();
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.func            = FUNC_WRITE;
    in_ch.src_mac         = '0;
    in_ch.data_byte       = '0;
    in_ch.byte_valid      = 1'b0;
    in_ch.end_of_datagram = 1'b0;
    in_ch.read_capacity   = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.enable         = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Out of reset the block is disabled: everything ignored, all-zero results.
    push_item(read_txn(8'd7));
    push_item(write_txn(48'h0123_4567_89ab, 8'h55, 1'b1, 1'b1));
    settle();
    write_enable_reg(1'b1);

    // Directed: empty ring read, empty datagram, extremes of mac and data,
    // a no-byte item mid-datagram, capacity 0 and over range, fill to full,
    // a tail-dropped datagram, and a read while a write is in progress.
    push_item(read_txn(8'd5));
    push_item(write_txn({MAC_W{1'b1}}, 8'h00, 1'b0, 1'b1));
    push_item(write_txn('0, 8'h00, 1'b1, 1'b0));
    push_item(write_txn({MAC_W{1'b1}}, 8'h77, 1'b0, 1'b0));
    push_item(write_txn('0, 8'hff, 1'b1, 1'b0));
    push_item(write_txn('0, 8'ha5, 1'b1, 1'b1));
    push_item(read_txn(8'd250));
    push_item(read_txn(8'd0));
    for (int k = 0; k < RING_SLOTS_DEF - 1; k++)
      push_item(write_txn(48'h5a5a_0000_0000 + 48'(k), 8'(8'h10 + k), 1'b1, 1'b1));
    push_item(write_txn(48'h0bad_0bad_0bad, 8'h3c, 1'b1, 1'b0));
    push_item(write_txn(48'h0bad_0bad_0bad, 8'hc3, 1'b1, 1'b1));
    push_item(read_txn(8'd255));
    push_item(read_txn(8'd1));
    push_item(write_txn(48'h8000_0000_0001, 8'h81, 1'b1, 1'b0));
    push_item(read_txn(8'd2));
    push_item(write_txn(48'h8000_0000_0001, 8'h18, 1'b1, 1'b1));
    settle();

    // Disable with datagrams still queued: ring emptied, drop count cleared.
    write_enable_reg(1'b0);
    settle();
    push_item(write_txn(48'h1111_2222_3333, 8'h44, 1'b1, 1'b1));
    settle();
    write_enable_reg(1'b1);

    // Random phases with varied read mix and idling; phase 1 runs with no
    // gaps at all. After phase 2 the block is disabled and re-enabled.
    for (int p = 0; p < 6; p++) begin
      gap_pct = (p == 1) ? 0 : $urandom_range(10, 45);
      run_random_phase(150, $urandom_range(30, 55));
      settle();
      if (p == 2) begin
        write_enable_reg(1'b0);
        settle();
        run_random_phase(6, 50);
        settle();
      end
      write_enable_reg(1'b1);
    end
    settle();

    if (shadow.mismatches == 0 && shadow.due_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
